/* rtl/core/kvt_pkg.sv */
package kvt_pkg;

  // Field and register widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KEY_LEN_W   = 8;
  localparam int unsigned VALUE_LEN_W = 12;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = VALUE_LEN_W;

  // Default depth of the token queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_MAX_LEN   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_MAX_LEN = 1'b1;

  // Register reset values
  localparam logic [KEY_LEN_W-1:0]   KEY_MAX_LEN_RST   = 8'd255;
  localparam logic [VALUE_LEN_W-1:0] VALUE_MAX_LEN_RST = 12'd2047;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    KIND_KEY_CHAR = 3'd0,
    KIND_KEY_END  = 3'd1,
    KIND_VAL_CHAR = 3'd2,
    KIND_VAL_END  = 3'd3,
    KIND_BAD_KEY  = 3'd4,
    KIND_BAD_VAL  = 3'd5,
    KIND_DONE     = 3'd6
  } token_kind_t;

  typedef enum logic [2:0] {
    PH_BEFORE_KEY = 3'd0,
    PH_IN_KEY     = 3'd1,
    PH_BEFORE_VAL = 3'd2,
    PH_QUOTED     = 3'd3,
    PH_UNQUOTED   = 3'd4,
    PH_IGNORE     = 3'd5
  } parse_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              message_end;
  } in_item_t;

  typedef struct packed {
    token_kind_t       token_kind;
    logic [BYTE_W-1:0] token_byte;
    logic              last_of_item;
  } out_item_t;

  // Up to two tokens written into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    out_item_t  tok0;
    out_item_t  tok1;
  } push_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

/* rtl/core/kvt_front.sv */
module kvt_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [kvt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [kvt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  kvt_pkg::in_item_t                   in_data,
  input  logic                                room,
  output kvt_pkg::push_t                      push
);

  logic [kvt_pkg::KEY_LEN_W-1:0]   key_max_len;
  logic [kvt_pkg::VALUE_LEN_W-1:0] value_max_len;

  kvt_pkg::parse_phase_t           phase, phase_next;
  logic [kvt_pkg::KEY_LEN_W-1:0]   key_length, key_length_next;
  logic [kvt_pkg::VALUE_LEN_W-1:0] value_length, value_length_next;

  logic                            accept;
  logic [kvt_pkg::BYTE_W-1:0]      c;
  logic [kvt_pkg::KEY_LEN_W-1:0]   key_base;
  logic [kvt_pkg::VALUE_LEN_W-1:0] value_base;
  logic                            key_room;
  logic                            value_room;
  logic                            close_valid;
  kvt_pkg::token_kind_t            close_kind;

  assign accept = in_valid && room;
  assign c      = in_data.data_byte;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_max_len   <= kvt_pkg::KEY_MAX_LEN_RST;
      value_max_len <= kvt_pkg::VALUE_MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kvt_pkg::CFG_KEY_MAX_LEN:   key_max_len   <= cfg_data[kvt_pkg::KEY_LEN_W-1:0];
        kvt_pkg::CFG_VALUE_MAX_LEN: value_max_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // A new key or value starts counting from zero
  assign key_base   = (phase == kvt_pkg::PH_BEFORE_KEY) ? '0 : key_length;
  assign value_base = (phase == kvt_pkg::PH_BEFORE_VAL) ? '0 : value_length;
  assign key_room   = key_base < key_max_len;
  assign value_room = value_base < value_max_len;

  // Token that closes the open construct on end item or zero byte
  always_comb begin
    close_valid = 1'b1;
    close_kind  = kvt_pkg::KIND_DONE;
    unique case (phase)
      kvt_pkg::PH_IN_KEY:     close_kind = kvt_pkg::KIND_BAD_KEY;
      kvt_pkg::PH_BEFORE_VAL: close_kind = kvt_pkg::KIND_BAD_VAL;
      kvt_pkg::PH_QUOTED:     close_kind = kvt_pkg::KIND_BAD_VAL;
      kvt_pkg::PH_UNQUOTED:   close_kind = kvt_pkg::KIND_VAL_END;
      default:                close_valid = 1'b0;
    endcase
  end

  // Parser: next state and emitted tokens
  always_comb begin
    phase_next        = phase;
    key_length_next   = key_length;
    value_length_next = value_length;
    push              = '0;
    push.tok0.token_kind = kvt_pkg::KIND_DONE;
    push.tok1.token_kind = kvt_pkg::KIND_DONE;

    if (accept) begin
      if (in_data.message_end) begin
        push.tok1.token_kind   = kvt_pkg::KIND_DONE;
        push.tok1.last_of_item = 1'b1;
        if (close_valid) begin
          push.count           = 2'd2;
          push.tok0.token_kind = close_kind;
        end else begin
          push.count             = 2'd1;
          push.tok0.token_kind   = kvt_pkg::KIND_DONE;
          push.tok0.last_of_item = 1'b1;
        end
        phase_next        = kvt_pkg::PH_BEFORE_KEY;
        key_length_next   = '0;
        value_length_next = '0;
      end else if (c == kvt_pkg::CH_NUL) begin
        if (close_valid) begin
          push.count             = 2'd1;
          push.tok0.token_kind   = close_kind;
          push.tok0.last_of_item = 1'b1;
        end
        phase_next = kvt_pkg::PH_IGNORE;
      end else begin
        push.tok0.last_of_item = 1'b1;
        unique case (phase)
          kvt_pkg::PH_BEFORE_KEY, kvt_pkg::PH_IN_KEY: begin
            if ((phase == kvt_pkg::PH_BEFORE_KEY) && kvt_pkg::is_blank(c)) begin
              // skip blanks between pairs
            end else if (kvt_pkg::is_blank(c) ||
                         ((phase == kvt_pkg::PH_BEFORE_KEY) && (c == kvt_pkg::CH_COLON))) begin
              phase_next           = kvt_pkg::PH_IGNORE;
              push.count           = 2'd1;
              push.tok0.token_kind = kvt_pkg::KIND_BAD_KEY;
            end else if (c == kvt_pkg::CH_COLON) begin
              phase_next           = kvt_pkg::PH_BEFORE_VAL;
              push.count           = 2'd1;
              push.tok0.token_kind = kvt_pkg::KIND_KEY_END;
            end else if (key_room) begin
              phase_next           = kvt_pkg::PH_IN_KEY;
              key_length_next      = key_base + 1'b1;
              push.count           = 2'd1;
              push.tok0.token_kind = kvt_pkg::KIND_KEY_CHAR;
              push.tok0.token_byte = c;
            end else begin
              phase_next           = kvt_pkg::PH_IGNORE;
              key_length_next      = key_base;
              push.count           = 2'd1;
              push.tok0.token_kind = kvt_pkg::KIND_BAD_KEY;
            end
          end
          kvt_pkg::PH_BEFORE_VAL: begin
            if (!kvt_pkg::is_blank(c)) begin
              value_length_next = '0;
              if (c == kvt_pkg::CH_QUOTE) begin
                phase_next = kvt_pkg::PH_QUOTED;
              end else begin
                phase_next = kvt_pkg::PH_UNQUOTED;
                if (value_room) begin
                  value_length_next    = 12'd1;
                  push.count           = 2'd1;
                  push.tok0.token_kind = kvt_pkg::KIND_VAL_CHAR;
                  push.tok0.token_byte = c;
                end
              end
            end
          end
          kvt_pkg::PH_QUOTED, kvt_pkg::PH_UNQUOTED: begin
            if (((phase == kvt_pkg::PH_QUOTED) && (c == kvt_pkg::CH_QUOTE)) ||
                ((phase == kvt_pkg::PH_UNQUOTED) && kvt_pkg::is_blank(c))) begin
              phase_next           = kvt_pkg::PH_BEFORE_KEY;
              push.count           = 2'd1;
              push.tok0.token_kind = kvt_pkg::KIND_VAL_END;
            end else if (value_room) begin
              // characters past the limit are dropped silently
              value_length_next    = value_length + 1'b1;
              push.count           = 2'd1;
              push.tok0.token_kind = kvt_pkg::KIND_VAL_CHAR;
              push.tok0.token_byte = c;
            end
          end
          default: begin
            phase_next = kvt_pkg::PH_IGNORE;
          end
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= kvt_pkg::PH_BEFORE_KEY;
      key_length   <= '0;
      value_length <= '0;
    end else begin
      phase        <= phase_next;
      key_length   <= key_length_next;
      value_length <= value_length_next;
    end
  end

  // An end item always leaves the parser ready for a new message
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.message_end) |=>
      (phase == kvt_pkg::PH_BEFORE_KEY && key_length == '0 && value_length == '0))
    else $error("parser not returned to start after end item");

endmodule

/* rtl/core/kvt_queue.sv */
module kvt_queue #(
  parameter int unsigned DEPTH = kvt_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  kvt_pkg::push_t     push,
  output logic               room,
  output logic               not_empty,
  output kvt_pkg::out_item_t head,
  input  logic               pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  kvt_pkg::out_item_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr, wr_ptr_1;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_1  = ptr_inc(wr_ptr);
  assign room      = count <= CNT_W'(DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  // Storage: up to two writes per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.tok1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.count == 2'd1) begin
        wr_ptr <= wr_ptr_1;
      end else if (push.count == 2'd2) begin
        wr_ptr <= ptr_inc(wr_ptr_1);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("token queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty token queue");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> $past(room) || $past(rst) || room)
    else $error("push without queue room");

endmodule

/* rtl/core/kvt_back.sv */
module kvt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               not_empty,
  input  kvt_pkg::out_item_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output kvt_pkg::out_item_t out_data
);

  logic out_valid_next;

  // Output register loads a queued token whenever it is empty or being taken
  assign pop            = not_empty && (!out_valid || !out_stall);
  assign out_valid_next = pop || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head;
    end
  end

endmodule

/* rtl/core/key_value_text_tokenizer_core.sv */
// Streaming key:value tokenizer. Takes one message byte per transaction (or an end
// transaction) and emits key/value character and boundary tokens in arrival order.
// Input transactions are taken at one per clock while in_stall is low; each yields
// zero, one or two tokens (two only for an end transaction that closes an open key
// or value). Tokens leave one per clock through a registered output while out_stall
// is low. in_stall rises when the token queue between parser and output stage has
// fewer than two free entries, so throughput is limited only by the output side: one
// token per clock. Configuration writes (index 0 key_max_len, index 1 value_max_len)
// take effect on the next clock and should only be issued while the block is idle.
module key_value_text_tokenizer_core #(
  parameter int unsigned QUEUE_DEPTH = kvt_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kvt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kvt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  kvt_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output kvt_pkg::out_item_t              out_data
);

  kvt_pkg::push_t     push;
  kvt_pkg::out_item_t head;
  logic               room;
  logic               not_empty;
  logic               pop;

  assign in_stall = !room;

  // Parser
  kvt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .room      (room),
    .push      (push)
  );

  // Token queue
  kvt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop)
  );

  // Output stage
  kvt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* bench/tb_key_value_text_tokenizer_core.sv */
`timescale 1ns / 100ps

module tb_key_value_text_tokenizer_core;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [kvt_pkg::CFG_INDEX_W-1:0]     cfg_index = kvt_pkg::CFG_KEY_MAX_LEN;
  logic [kvt_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  kvt_pkg::in_item_t                   in_data = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  kvt_pkg::out_item_t                  out_data;

  key_value_text_tokenizer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow parser state and limits
  kvt_pkg::parse_phase_t           phase = kvt_pkg::PH_BEFORE_KEY;
  logic [kvt_pkg::KEY_LEN_W-1:0]   key_len = '0;
  logic [kvt_pkg::KEY_LEN_W-1:0]   key_max = kvt_pkg::KEY_MAX_LEN_RST;
  logic [kvt_pkg::VALUE_LEN_W-1:0] val_len = '0;
  logic [kvt_pkg::VALUE_LEN_W-1:0] val_max = kvt_pkg::VALUE_MAX_LEN_RST;

  kvt_pkg::out_item_t expected_tokens[$];
  kvt_pkg::out_item_t step_tokens[$];
  logic [7:0]         msg_bytes[$];

  int mismatch_count = 0;
  int tokens_checked = 0;
  int items_sent = 0;
  int messages_sent = 0;
  int settings_used = 1;
  int stall_left = 0;
  bit gaps_on = 1'b1;

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit blank_char(input logic [7:0] c);
    case (c)
      kvt_pkg::CH_SPACE, kvt_pkg::CH_TAB, kvt_pkg::CH_LF, kvt_pkg::CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_token(input kvt_pkg::token_kind_t kind, input logic [7:0] c);
    kvt_pkg::out_item_t t;
    t.token_kind   = kind;
    t.token_byte   = c;
    t.last_of_item = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void take_key_char(input logic [7:0] c);
    if (key_len < key_max) begin
      key_len = key_len + 1'b1;
      phase = kvt_pkg::PH_IN_KEY;
      add_token(kvt_pkg::KIND_KEY_CHAR, c);
    end else begin
      phase = kvt_pkg::PH_IGNORE;
      add_token(kvt_pkg::KIND_BAD_KEY, 8'h00);
    end
  endfunction

  // Value characters past the limit are dropped silently
  function automatic void take_value_char(input logic [7:0] c);
    if (val_len < val_max) begin
      val_len = val_len + 1'b1;
      add_token(kvt_pkg::KIND_VAL_CHAR, c);
    end
  endfunction

  // Advance the shadow parser by one input transaction, queue its tokens
  function automatic void tokenize_item(input kvt_pkg::in_item_t it);
    logic [7:0]         c;
    kvt_pkg::out_item_t t;
    c = it.data_byte;
    step_tokens.delete();
    if (it.message_end || c == kvt_pkg::CH_NUL) begin
      // end item and early zero byte close the open token the same way
      case (phase)
        kvt_pkg::PH_IN_KEY:
          add_token(kvt_pkg::KIND_BAD_KEY, 8'h00);
        kvt_pkg::PH_BEFORE_VAL, kvt_pkg::PH_QUOTED:
          add_token(kvt_pkg::KIND_BAD_VAL, 8'h00);
        kvt_pkg::PH_UNQUOTED:
          add_token(kvt_pkg::KIND_VAL_END, 8'h00);
        default: ;
      endcase
      if (it.message_end) begin
        add_token(kvt_pkg::KIND_DONE, 8'h00);
        phase = kvt_pkg::PH_BEFORE_KEY;
        key_len = '0;
        val_len = '0;
      end else begin
        phase = kvt_pkg::PH_IGNORE;
      end
    end else begin
      case (phase)
        kvt_pkg::PH_BEFORE_KEY: begin
          if (c == kvt_pkg::CH_COLON) begin
            phase = kvt_pkg::PH_IGNORE;
            add_token(kvt_pkg::KIND_BAD_KEY, 8'h00);
          end else if (!blank_char(c)) begin
            key_len = '0;
            take_key_char(c);
          end
        end
        kvt_pkg::PH_IN_KEY: begin
          if (blank_char(c)) begin
            phase = kvt_pkg::PH_IGNORE;
            add_token(kvt_pkg::KIND_BAD_KEY, 8'h00);
          end else if (c == kvt_pkg::CH_COLON) begin
            phase = kvt_pkg::PH_BEFORE_VAL;
            add_token(kvt_pkg::KIND_KEY_END, 8'h00);
          end else begin
            take_key_char(c);
          end
        end
        kvt_pkg::PH_BEFORE_VAL: begin
          if (!blank_char(c)) begin
            val_len = '0;
            if (c == kvt_pkg::CH_QUOTE) begin
              phase = kvt_pkg::PH_QUOTED;
            end else begin
              phase = kvt_pkg::PH_UNQUOTED;
              take_value_char(c);
            end
          end
        end
        kvt_pkg::PH_QUOTED: begin
          if (c == kvt_pkg::CH_QUOTE) begin
            phase = kvt_pkg::PH_BEFORE_KEY;
            add_token(kvt_pkg::KIND_VAL_END, 8'h00);
          end else begin
            take_value_char(c);
          end
        end
        kvt_pkg::PH_UNQUOTED: begin
          if (blank_char(c)) begin
            phase = kvt_pkg::PH_BEFORE_KEY;
            add_token(kvt_pkg::KIND_VAL_END, 8'h00);
          end else begin
            take_value_char(c);
          end
        end
        default: phase = kvt_pkg::PH_IGNORE;
      endcase
    end
    if (step_tokens.size() != 0) begin
      t = step_tokens.pop_back();
      t.last_of_item = 1'b1;
      step_tokens.push_back(t);
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic void report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t mismatch: %s", $time, what);
  endfunction

  // Predict on accepted input transactions, check accepted output transactions
  always @(posedge clk) begin : monitor
    kvt_pkg::out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        items_sent++;
        tokenize_item(in_data);
      end
      if (out_valid && !out_stall) begin
        tokens_checked++;
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d byte %02h last %0b",
                                    out_data.token_kind, out_data.token_byte,
                                    out_data.last_of_item));
        end else begin
          want = expected_tokens.pop_front();
          if (out_data.token_kind !== want.token_kind ||
              out_data.token_byte !== want.token_byte ||
              out_data.last_of_item !== want.last_of_item)
            report_mismatch($sformatf(
              "expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
              want.token_kind, want.token_byte, want.last_of_item,
              out_data.token_kind, out_data.token_byte, out_data.last_of_item));
        end
      end
    end
  end

  // Output-side back-pressure
  always @(negedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_stall = (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // One input transaction; valid stays up when the next one follows at once
  task automatic send_item(input kvt_pkg::in_item_t it);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do begin
      @(posedge clk);
    end while (in_stall);
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] c);
    kvt_pkg::in_item_t it;
    it.data_byte = c;
    it.message_end = 1'b0;
    send_item(it);
  endtask

  task automatic send_end();
    kvt_pkg::in_item_t it;
    it.data_byte = 8'($urandom_range(0, 255));  // don't care on the end item
    it.message_end = 1'b1;
    send_item(it);
    messages_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  // Drained plus pipeline slack, so nothing is left in flight
  task automatic settle_block();
    wait_drained();
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kvt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [kvt_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == kvt_pkg::CFG_KEY_MAX_LEN) key_max = d[kvt_pkg::KEY_LEN_W-1:0];
    else val_max = d[kvt_pkg::VALUE_LEN_W-1:0];
  endtask

  task automatic set_limits(input int k, input int v);
    logic [kvt_pkg::CFG_DATA_W-1:0] d;
    settle_block();
    d = kvt_pkg::CFG_DATA_W'($urandom);  // upper bits are not part of the key limit
    d[kvt_pkg::KEY_LEN_W-1:0] = kvt_pkg::KEY_LEN_W'(k);
    write_reg(kvt_pkg::CFG_KEY_MAX_LEN, d);
    write_reg(kvt_pkg::CFG_VALUE_MAX_LEN, kvt_pkg::CFG_DATA_W'(v));
    settings_used++;
  endtask

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 3))
      0:       return kvt_pkg::CH_SPACE;
      1:       return kvt_pkg::CH_TAB;
      2:       return kvt_pkg::CH_LF;
      default: return kvt_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] random_char(input logic [7:0] banned, input bit blanks_ok);
    logic [7:0] c;
    if (blanks_ok && $urandom_range(0, 5) == 0) return random_blank();
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == banned || (!blanks_ok && blank_char(c)));
    return c;
  endfunction

  // Build a message of well-formed pairs, then damage some of them
  function automatic void compose_message();
    int pairs, klen, vlen, vtop, pos;
    bit quoted;
    msg_bytes.delete();
    pairs = $urandom_range(0, 4);
    for (int p = 0; p < pairs; p++) begin
      repeat ($urandom_range(0, 2)) msg_bytes.push_back(random_blank());
      if ($urandom_range(0, 19) == 0) klen = $urandom_range(1, int'(key_max) + 1);
      else klen = $urandom_range(1, (key_max < 8) ? int'(key_max) + 1 : 8);
      repeat (klen) msg_bytes.push_back(random_char(kvt_pkg::CH_COLON, 1'b0));
      msg_bytes.push_back(kvt_pkg::CH_COLON);
      repeat ($urandom_range(0, 2)) msg_bytes.push_back(random_blank());
      vtop = (val_max < 12) ? int'(val_max) + 2 : 10;
      vlen = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 60) : $urandom_range(0, vtop);
      quoted = ($urandom_range(0, 1) != 0);
      if (quoted) begin
        msg_bytes.push_back(kvt_pkg::CH_QUOTE);
        repeat (vlen) msg_bytes.push_back(random_char(kvt_pkg::CH_QUOTE, 1'b1));
        msg_bytes.push_back(kvt_pkg::CH_QUOTE);
      end else begin
        repeat ((vlen == 0) ? 1 : vlen)
          msg_bytes.push_back(random_char(kvt_pkg::CH_QUOTE, 1'b0));
        // the last unquoted value may be left for the end item to close
        if (p != pairs - 1 || $urandom_range(0, 1)) msg_bytes.push_back(random_blank());
      end
    end
    case ($urandom_range(0, 9))
      7: begin
        msg_bytes.delete();
        repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        pos = $urandom_range(0, msg_bytes.size());
        while (msg_bytes.size() > pos) msg_bytes.delete(msg_bytes.size() - 1);
      end
      9: begin
        if (msg_bytes.size() != 0) begin
          pos = $urandom_range(0, msg_bytes.size() - 1);
          case ($urandom_range(0, 4))
            0:       msg_bytes[pos] = kvt_pkg::CH_NUL;
            1:       msg_bytes[pos] = kvt_pkg::CH_COLON;
            2:       msg_bytes[pos] = kvt_pkg::CH_QUOTE;
            3:       msg_bytes[pos] = kvt_pkg::CH_SPACE;
            default: msg_bytes[pos] = 8'($urandom_range(0, 255));
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_message();
    int pause_at;
    compose_message();
    pause_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, msg_bytes.size()) : -1;
    foreach (msg_bytes[i]) begin
      if (i == pause_at) wait_drained();
      send_byte(msg_bytes[i]);
    end
    send_end();
  endtask

  // Byte extremes and a quoted value, at reset limits
  task automatic test_field_extremes();
    send_byte(8'hFF);
    send_byte(kvt_pkg::CH_COLON);
    send_byte(kvt_pkg::CH_QUOTE);
    send_byte(8'h01);
    send_byte(kvt_pkg::CH_QUOTE);
    send_end();
  endtask

  // Empty key, over-long key with ignored tail, blank inside a key
  task automatic test_key_errors();
    set_limits(2, 1);
    send_byte(kvt_pkg::CH_COLON);
    send_end();
    send_text("abc");
    send_end();
    send_text("a ");
    send_end();
  endtask

  // Dropped value characters, then an unclosed quote at the end item
  task automatic test_value_truncation();
    send_text("k:\"xy");
    send_end();
  endtask

  // Zero byte between pairs, while waiting for a value, inside an unquoted value
  task automatic test_zero_byte();
    send_byte(kvt_pkg::CH_NUL);
    send_end();
    send_text("a:");
    send_byte(kvt_pkg::CH_NUL);
    send_end();
    send_text("a:b");
    send_byte(kvt_pkg::CH_NUL);
    send_end();
  endtask

  // End item inside a key and before a value
  task automatic test_end_item();
    send_byte("a");
    send_end();
    send_text("a:");
    send_end();
  endtask

  // Sender holds off mid-message until every token is out
  task automatic test_drain_pause();
    send_text("ab:c");
    wait_drained();
    send_text(" d:e");
    send_end();
  endtask

  task automatic test_random_messages(input int k, input int v, input int count);
    int stop_at;
    set_limits(k, v);
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      send_message();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_key_errors();
    test_value_truncation();
    test_zero_byte();
    test_end_item();
    test_drain_pause();
    test_random_messages(255, 2047, 180);
    test_random_messages(1, 1, 180);
    test_random_messages(255, 4095, 180);
    test_random_messages(4, 6, 180);
    test_random_messages(9, 3, 180);
    settle_block();

    $display("Tokenized %0d messages (%0d input items) under %0d limit settings",
             messages_sent, items_sent, settings_used);
    $display("Checked %0d tokens, %0d mismatches", tokens_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/kvt_pkg.sv
rtl/core/kvt_front.sv
rtl/core/kvt_queue.sv
rtl/core/kvt_back.sv
rtl/core/key_value_text_tokenizer_core.sv
bench/tb_key_value_text_tokenizer_core.sv
